### design/ttvb_pkg.sv
// ============================================================================
// ttvb_pkg
// Shared types and constants of the tapered trail vertex builder.
// ============================================================================
package ttvb_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    localparam logic [15:0] DECAY_RESET = 16'd6554;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam int          UNIT_SHIFT  = 30;
    localparam logic [1:0]  LAST_CORNER = 2'd3;

endpackage

### design/tapered_trail_vertex_builder_top.sv
// ============================================================================
// tapered_trail_vertex_builder_top
// Extrudes a stored polyline into a tapered tube of corner vertices.
// ============================================================================
// Points enter on the input channel (valid/ready), one per cycle, into a
// circular store of MAX_POINTS entries; a full store drops its oldest point.
// A point with final_point set starts a build over the stored points. While
// a build runs the input channel holds ready low, and it opens again on the
// clock edge at which the last vertex of the build enters the output register.
// Each kept point yields four vertices on the output channel (valid/ready),
// oldest point first, corners 0 to 3; last_vertex marks the end of a build.
// A build first drops the oldest points while their width would be zero or
// less, keeping at least two, and then for each kept point makes three
// passes through the shared normalizer (bit-serial shifting, square root and
// division) before it forms the four vertices of that point.
// A build with fewer than two points produces no vertex.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties the store and sets width_decay to 6554; the configuration
// write is taken at once and must occur only while no build is in progress.
// ============================================================================
module tapered_trail_vertex_builder_top #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               final_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [1:0]         corner,
    output logic [3:0]         kept_point,
    output logic               last_vertex
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [15:0]      width_decay_reg;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [PW-1:0]    cmd_head;
    logic [CW-1:0]    cmd_count;
    logic [PW+CW-1:0] q_dout;
    logic             build_done;
    logic             front_busy;
    logic [PW-1:0]    rd_addr_a;
    logic [PW-1:0]    rd_addr_b;
    ttvb_pkg::point_t rd_data_a;
    ttvb_pkg::point_t rd_data_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_decay_reg <= ttvb_pkg::DECAY_RESET;
        end
        else if (cfg_write_en)
        begin
            width_decay_reg <= cfg_write_data;
        end
    end

    ttvb_front #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW),
        .CW         (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .final_point (final_point),
        .push        (q_push),
        .cmd_head    (cmd_head),
        .cmd_count   (cmd_count),
        .q_full      (q_full),
        .build_done  (build_done),
        .busy        (front_busy),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b)
    );

    ttvb_cmd_q #(
        .W (PW + CW)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({cmd_head, cmd_count}),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    ttvb_back #(
        .MAX_POINTS (MAX_POINTS),
        .PW         (PW),
        .CW         (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .width_decay (width_decay_reg),
        .q_valid     (q_valid),
        .q_head      (q_dout[PW+CW-1:CW]),
        .q_count     (q_dout[CW-1:0]),
        .q_pop       (q_pop),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .build_done  (build_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .vertex_z    (vertex_z),
        .corner      (corner),
        .kept_point  (kept_point),
        .last_vertex (last_vertex)
    );

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_vertex |-> corner == ttvb_pkg::LAST_CORNER)
        else $error("last vertex on a corner other than the last");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        build_done |-> front_busy)
        else $error("build finished with no build pending");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("build command pushed into a full queue");

endmodule

### design/ttvb_front.sv
// ============================================================================
// ttvb_front
// Accepts points into the circular point store and issues build commands.
// ============================================================================
module ttvb_front #(
    parameter int MAX_POINTS = 16,
    parameter int PW         = 4,
    parameter int CW         = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [31:0]     point_x,
    input  logic signed [31:0]     point_y,
    input  logic signed [31:0]     point_z,
    input  logic                   final_point,
    output logic                   push,
    output logic [PW-1:0]          cmd_head,
    output logic [CW-1:0]          cmd_count,
    input  logic                   q_full,
    input  logic                   build_done,
    output logic                   busy,
    input  logic [PW-1:0]          rd_addr_a,
    input  logic [PW-1:0]          rd_addr_b,
    output ttvb_pkg::point_t       rd_data_a,
    output ttvb_pkg::point_t       rd_data_b
);

    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);
    localparam logic [PW:0]   MAXW = (PW + 1)'(MAX_POINTS);

    ttvb_pkg::point_t mem [MAX_POINTS];

    logic [PW-1:0] head_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          accept;
    logic          at_full;
    logic [PW:0]   inc_sum;
    logic [PW:0]   end_sum;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] head_new;
    logic [PW-1:0] wr_addr;
    logic [CW-1:0] cnt_new;

    assign in_ready = !busy_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign at_full  = (cnt_reg == FULL);
    assign busy     = busy_reg;

    always_comb
    begin
        inc_sum  = {1'b0, head_reg} + (PW + 1)'(1);
        head_inc = (inc_sum >= MAXW) ? PW'(inc_sum - MAXW) : inc_sum[PW-1:0];
        end_sum  = {1'b0, head_reg} + (PW + 1)'(cnt_reg);
        wr_addr  = at_full ? head_reg
                 : ((end_sum >= MAXW) ? PW'(end_sum - MAXW) : end_sum[PW-1:0]);
        head_new = at_full ? head_inc : head_reg;
        cnt_new  = at_full ? cnt_reg : cnt_reg + CW'(1);
    end

    assign push      = accept && final_point && (cnt_new >= CW'(2));
    assign cmd_head  = head_new;
    assign cmd_count = cnt_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (build_done)
            begin
                busy_reg <= 1'b0;
            end
            if (accept)
            begin
                head_reg <= head_new;
                if (final_point)
                begin
                    cnt_reg <= '0;
                    if (cnt_new >= CW'(2))
                    begin
                        busy_reg <= 1'b1;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_addr] <= '{x: point_x, y: point_y, z: point_z};
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### design/ttvb_cmd_q.sv
// ============================================================================
// ttvb_cmd_q
// Two-entry queue of build commands between the front and the back.
// ============================================================================
module ttvb_cmd_q #(
    parameter int W = 9
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] dout
);

    logic [W-1:0] data_reg [2];
    logic [1:0]   cnt_reg;
    logic         wp_reg;
    logic         rp_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = data_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop && valid)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            data_reg[wp_reg] <= din;
        end
    end

endmodule

### design/ttvb_norm.sv
// ============================================================================
// ttvb_norm
// Iterative vector normalizer: scale, sum of squares, square root, divide.
// ============================================================================
module ttvb_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] vin [3],
    output logic               done,
    output logic signed [31:0] vout [3]
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_SQ    = 6'b000100,
        S_SQRT  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } norm_state_t;

    norm_state_t state_reg;
    logic [62:0] mag_reg [3];
    logic        neg_reg [3];
    logic [62:0] m_reg;
    logic [62:0] rem_reg;
    logic [62:0] res_reg;
    logic [62:0] bit_reg;
    logic [1:0]  ci_reg;
    logic [4:0]  step_reg;
    logic [30:0] q_reg;
    logic [30:0] drem_reg;

    logic [62:0] mag_in [3];
    logic [62:0] m_in;
    logic [59:0] sq;
    logic [62:0] trial;
    logic [30:0] len;
    logic [30:0] mg;
    logic [31:0] t;
    logic        qb;
    logic [30:0] q_fin;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vin[i][63] ? 63'(-vin[i]) : vin[i][62:0];
        end
        m_in = mag_in[0];
        if (mag_in[1] > m_in)
        begin
            m_in = mag_in[1];
        end
        if (mag_in[2] > m_in)
        begin
            m_in = mag_in[2];
        end
        sq    = mag_reg[ci_reg][29:0] * mag_reg[ci_reg][29:0];
        trial = res_reg + bit_reg;
        len   = res_reg[30:0];
        mg    = {1'b0, mag_reg[ci_reg][29:0]};
        t     = {drem_reg, 1'b0};
        qb    = (t >= {1'b0, len});
        q_fin = {q_reg[29:0], qb};
    end

    assign done = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (m_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (m_reg[62:30] == '0 && m_reg[29])
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (ci_reg == 2'd2)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == 5'd30 && ci_reg == 2'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= mag_in[i];
                    neg_reg[i] <= vin[i][63];
                end
                m_reg <= m_in;
            end
            S_SCALE:
            begin
                if (m_reg == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vout[i] <= '0;
                    end
                end
                else if (m_reg[62:30] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                else
                begin
                    ci_reg  <= 2'd0;
                    rem_reg <= '0;
                end
            end
            S_SQ:
            begin
                rem_reg <= rem_reg + 63'(sq);
                if (ci_reg == 2'd2)
                begin
                    ci_reg  <= 2'd0;
                    res_reg <= '0;
                    bit_reg <= 63'(1) << 62;
                end
                else
                begin
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            S_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= '0;
            end
            S_DIV:
            begin
                if (step_reg == 5'd0)
                begin
                    if (mg >= len)
                    begin
                        q_reg    <= 31'd1;
                        drem_reg <= mg - len;
                    end
                    else
                    begin
                        q_reg    <= 31'd0;
                        drem_reg <= mg;
                    end
                    step_reg <= 5'd1;
                end
                else
                begin
                    q_reg    <= q_fin;
                    drem_reg <= qb ? 31'(t - {1'b0, len}) : t[30:0];
                    if (step_reg == 5'd30)
                    begin
                        vout[ci_reg] <= neg_reg[ci_reg] ? -$signed({1'b0, q_fin})
                                                        : $signed({1'b0, q_fin});
                        ci_reg       <= ci_reg + 2'd1;
                        step_reg     <= 5'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
            end
            S_DONE:
            begin
                ci_reg <= 2'd0;
            end
            default:
            begin
                ci_reg <= 2'd0;
            end
        endcase
    end

endmodule

### design/ttvb_back.sv
// ============================================================================
// ttvb_back
// Build sequencer: trims the tail, forms the axes of each kept point and
// emits its four corner vertices through an output register.
// ============================================================================
module ttvb_back #(
    parameter int MAX_POINTS = 16,
    parameter int PW         = 4,
    parameter int CW         = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        width_decay,
    input  logic               q_valid,
    input  logic [PW-1:0]      q_head,
    input  logic [CW-1:0]      q_count,
    output logic               q_pop,
    output logic [PW-1:0]      rd_addr_a,
    output logic [PW-1:0]      rd_addr_b,
    input  ttvb_pkg::point_t   rd_data_a,
    input  ttvb_pkg::point_t   rd_data_b,
    output logic               build_done,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [1:0]         corner,
    output logic [3:0]         kept_point,
    output logic               last_vertex
);

    localparam logic [PW:0] MAXW = (PW + 1)'(MAX_POINTS);

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_TRIM  = 10'b0000000010,
        B_RD    = 10'b0000000100,
        B_RDW   = 10'b0000001000,
        B_NDIR  = 10'b0000010000,
        B_NSIDE = 10'b0000100000,
        B_MUL   = 10'b0001000000,
        B_NUP   = 10'b0010000000,
        B_VTX   = 10'b0100000000,
        B_OUT   = 10'b1000000000
    } back_state_t;

    back_state_t        state_reg;
    logic [PW-1:0]      head_reg;
    logic [CW-1:0]      n_reg;
    logic [PW-1:0]      k_reg;
    logic [1:0]         c_reg;
    logic [2:0]         sub_reg;
    logic [2:0]         mi_reg;
    logic               start_reg;
    logic [16:0]        w_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [63:0] vec_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] side_reg [3];
    logic signed [31:0] up_reg [3];
    logic signed [63:0] p_reg [4];
    logic signed [50:0] prod_reg;
    logic signed [31:0] coord_reg [3];

    logic               norm_done;
    logic signed [31:0] norm_out [3];
    logic [CW+15:0]     trim_prod;
    logic [CW+16:0]     w_full;
    logic [PW:0]        inc_sum;
    logic [PW-1:0]      head_inc;
    logic [PW-1:0]      idx_a;
    logic [PW-1:0]      idx_b;
    logic [PW:0]        sum_a;
    logic [PW:0]        sum_b;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic [1:0]         j;
    logic signed [32:0] sumv;
    logic signed [63:0] acc;
    logic signed [33:0] qv;
    logic signed [31:0] coord_sat;
    logic               is_last;
    logic               load;
    logic               tail_dead;

    ttvb_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .vin   (vec_reg),
        .done  (norm_done),
        .vout  (norm_out)
    );

    always_comb
    begin
        trim_prod = (n_reg - CW'(1)) * width_decay;
        tail_dead = (n_reg > CW'(2)) && (trim_prod >= (CW + 16)'(ttvb_pkg::ONE_Q16));
        w_full    = (CW + 17)'(ttvb_pkg::ONE_Q16)
                  - (CW + 17)'((n_reg - CW'(1) - CW'(k_reg)) * width_decay);
        inc_sum   = {1'b0, head_reg} + (PW + 1)'(1);
        head_inc  = (inc_sum >= MAXW) ? PW'(inc_sum - MAXW) : inc_sum[PW-1:0];
        idx_a     = (k_reg == '0) ? PW'(0) : k_reg - PW'(1);
        idx_b     = (k_reg == '0) ? PW'(1) : k_reg;
        sum_a     = {1'b0, head_reg} + {1'b0, idx_a};
        sum_b     = {1'b0, head_reg} + {1'b0, idx_b};
        rd_addr_a = (sum_a >= MAXW) ? PW'(sum_a - MAXW) : sum_a[PW-1:0];
        rd_addr_b = (sum_b >= MAXW) ? PW'(sum_b - MAXW) : sum_b[PW-1:0];

        unique case (mi_reg[1:0])
            2'd0:    begin mul_a = dir_reg[1]; mul_b = side_reg[2]; end
            2'd1:    begin mul_a = dir_reg[2]; mul_b = side_reg[0]; end
            2'd2:    begin mul_a = dir_reg[0]; mul_b = side_reg[2]; end
            default: begin mul_a = dir_reg[1]; mul_b = side_reg[0]; end
        endcase
        mul_p = mul_a * mul_b;

        j    = sub_reg[2:1];
        sumv = (c_reg[0] ? -33'(side_reg[j]) : 33'(side_reg[j]))
             + (c_reg[1] ? -33'(up_reg[j]) : 33'(up_reg[j]));
        acc  = (64'(pos_reg[j]) <<< ttvb_pkg::UNIT_SHIFT) + 64'(prod_reg)
             + (64'sd1 <<< (ttvb_pkg::UNIT_SHIFT - 1));
        qv   = 34'(acc >>> ttvb_pkg::UNIT_SHIFT);
        if (qv > 34'sh7FFFFFFF)
        begin
            coord_sat = 32'sh7FFFFFFF;
        end
        else if (qv < -34'sh80000000)
        begin
            coord_sat = 32'sh80000000;
        end
        else
        begin
            coord_sat = qv[31:0];
        end

        is_last = (CW'(k_reg) == n_reg - CW'(1)) && (c_reg == ttvb_pkg::LAST_CORNER);
        load    = (state_reg == B_OUT) && (!out_valid || out_ready);
    end

    assign q_pop      = (state_reg == B_IDLE) && q_valid;
    assign build_done = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            start_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= B_TRIM;
                    end
                end
                B_TRIM:
                begin
                    if (!tail_dead)
                    begin
                        state_reg <= B_RD;
                    end
                end
                B_RD:
                begin
                    state_reg <= B_RDW;
                end
                B_RDW:
                begin
                    start_reg <= 1'b1;
                    state_reg <= B_NDIR;
                end
                B_NDIR:
                begin
                    if (norm_done)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= B_NSIDE;
                    end
                end
                B_NSIDE:
                begin
                    if (norm_done)
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    if (mi_reg == 3'd4)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= B_NUP;
                    end
                end
                B_NUP:
                begin
                    if (norm_done)
                    begin
                        state_reg <= B_VTX;
                    end
                end
                B_VTX:
                begin
                    if (sub_reg == 3'd5)
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (load)
                    begin
                        if (is_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else if (c_reg == ttvb_pkg::LAST_CORNER)
                        begin
                            state_reg <= B_RD;
                        end
                        else
                        begin
                            state_reg <= B_VTX;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                head_reg <= q_head;
                n_reg    <= q_count;
                k_reg    <= '0;
            end
            B_TRIM:
            begin
                if (tail_dead)
                begin
                    head_reg <= head_inc;
                    n_reg    <= n_reg - CW'(1);
                end
            end
            B_RD:
            begin
                w_reg <= w_full[16:0];
                c_reg <= 2'd0;
            end
            B_RDW:
            begin
                vec_reg[0] <= 64'(rd_data_b.x) - 64'(rd_data_a.x);
                vec_reg[1] <= 64'(rd_data_b.y) - 64'(rd_data_a.y);
                vec_reg[2] <= 64'(rd_data_b.z) - 64'(rd_data_a.z);
                if (k_reg == '0)
                begin
                    pos_reg[0] <= rd_data_a.x;
                    pos_reg[1] <= rd_data_a.y;
                    pos_reg[2] <= rd_data_a.z;
                end
                else
                begin
                    pos_reg[0] <= rd_data_b.x;
                    pos_reg[1] <= rd_data_b.y;
                    pos_reg[2] <= rd_data_b.z;
                end
            end
            B_NDIR:
            begin
                if (norm_done)
                begin
                    dir_reg    <= norm_out;
                    vec_reg[0] <= 64'(norm_out[2]);
                    vec_reg[1] <= '0;
                    vec_reg[2] <= -64'(norm_out[0]);
                end
            end
            B_NSIDE:
            begin
                side_reg <= norm_out;
                mi_reg   <= 3'd0;
            end
            B_MUL:
            begin
                if (mi_reg == 3'd4)
                begin
                    vec_reg[0] <= p_reg[0];
                    vec_reg[1] <= p_reg[1] - p_reg[2];
                    vec_reg[2] <= -p_reg[3];
                end
                else
                begin
                    p_reg[mi_reg[1:0]] <= mul_p;
                    mi_reg             <= mi_reg + 3'd1;
                end
            end
            B_NUP:
            begin
                up_reg  <= norm_out;
                sub_reg <= 3'd0;
            end
            B_VTX:
            begin
                if (!sub_reg[0])
                begin
                    prod_reg <= 51'(sumv * $signed({1'b0, w_reg}));
                end
                else
                begin
                    coord_reg[j] <= coord_sat;
                end
                sub_reg <= sub_reg + 3'd1;
            end
            B_OUT:
            begin
                if (load)
                begin
                    vertex_x    <= coord_reg[0];
                    vertex_y    <= coord_reg[1];
                    vertex_z    <= coord_reg[2];
                    corner      <= c_reg;
                    kept_point  <= 4'(k_reg);
                    last_vertex <= is_last;
                    sub_reg     <= 3'd0;
                    if (c_reg == ttvb_pkg::LAST_CORNER)
                    begin
                        k_reg <= k_reg + PW'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                sub_reg <= 3'd0;
            end
        endcase
    end

endmodule

### tb/tb_top.sv
// ============================================================================
// Tapered trail vertex builder testbench
// Loads polylines into the block, predicts every corner vertex of each build
// with a fixed-point model of its own, and checks the vertex stream in order
// under random idling on both channels and several width_decay settings.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 16;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [1:0] crn;
        logic [3:0] kp;
        logic lastv;
    } vertex_t;

    class vertex_scoreboard;
        vertex_t pending[$];
        logic [15:0] decay;
        longint sx[MAX_PTS];
        longint sy[MAX_PTS];
        longint sz[MAX_PTS];
        int count;
        int errors;
        int checked;
        int builds;

        function new();
            decay = 16'd6554;
            count = 0;
            errors = 0;
            checked = 0;
            builds = 0;
        endfunction

        function void drop_oldest();
            for (int i = 1; i < count; i++)
            begin
                sx[i-1] = sx[i];
                sy[i-1] = sy[i];
                sz[i-1] = sz[i];
            end
            if (count > 0)
                count--;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function void unit_vec(input longint v[3], output longint o[3]);
            longint unsigned mag[3];
            longint unsigned m;
            longint unsigned sum;
            longint unsigned len;
            longint q;
            m = 0;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = (v[i] < 0) ? -v[i] : v[i];
                if (mag[i] > m)
                    m = mag[i];
            end
            if (m == 0)
            begin
                o[0] = 0; o[1] = 0; o[2] = 0;
                return;
            end
            while (m >= (64'd1 << 30))
            begin
                m >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (m < (64'd1 << 29))
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = longint'((mag[i] << 30) / len);
                o[i] = (v[i] < 0) ? -q : q;
            end
        endfunction

        function logic signed [31:0] corner_coord(longint pos, longint a, longint b,
                                                  longint w);
            longint acc;
            longint q;
            acc = pos * (64'sd1 << 30) + (a + b) * w + (64'sd1 << 29);
            q = acc >>> 30;
            if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
            if (q < -64'sh80000000) q = -64'sh80000000;
            return q[31:0];
        endfunction

        function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz, logic fin);
            longint d[3], dir[3], sraw[3], sd[3], uraw[3], up[3], w, ss, su;
            int n, a, b;
            vertex_t v;
            if (count >= MAX_PTS)
                drop_oldest();
            sx[count] = px;
            sy[count] = py;
            sz[count] = pz;
            count++;
            if (!fin)
                return;
            n = count;
            if (n >= 2)
            begin
                builds++;
                while (n > 2 && 65536 - longint'(n - 1) * longint'(decay) <= 0)
                begin
                    drop_oldest();
                    n = count;
                end
                for (int k = 0; k < n; k++)
                begin
                    a = (k == 0) ? 0 : k - 1;
                    b = (k == 0) ? 1 : k;
                    d[0] = sx[b] - sx[a];
                    d[1] = sy[b] - sy[a];
                    d[2] = sz[b] - sz[a];
                    unit_vec(d, dir);
                    sraw[0] = dir[2]; sraw[1] = 0; sraw[2] = -dir[0];
                    unit_vec(sraw, sd);
                    uraw[0] = dir[1] * sd[2] - dir[2] * sd[1];
                    uraw[1] = dir[2] * sd[0] - dir[0] * sd[2];
                    uraw[2] = dir[0] * sd[1] - dir[1] * sd[0];
                    unit_vec(uraw, up);
                    w = 65536 - longint'(n - 1 - k) * longint'(decay);
                    for (int c = 0; c < 4; c++)
                    begin
                        ss = c[0] ? -1 : 1;
                        su = c[1] ? -1 : 1;
                        v.vx = corner_coord(sx[k], ss * sd[0], su * up[0], w);
                        v.vy = corner_coord(sy[k], ss * sd[1], su * up[1], w);
                        v.vz = corner_coord(sz[k], ss * sd[2], su * up[2], w);
                        v.crn = c[1:0];
                        v.kp = k[3:0];
                        v.lastv = (k == n - 1) && (c == 3);
                        pending.insert(pending.size(), v);
                    end
                end
            end
            count = 0;
        endfunction

        function void report(string what, longint got, longint exp_val);
            $display("MISMATCH %s: got %0h expected %0h", what, got, exp_val);
            errors++;
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected vertex_x", got.vx, 0);
                return;
            end
            e = pending.pop_front();
            if (got.vx !== e.vx) report("vertex_x", got.vx, e.vx);
            if (got.vy !== e.vy) report("vertex_y", got.vy, e.vy);
            if (got.vz !== e.vz) report("vertex_z", got.vz, e.vz);
            if (got.crn !== e.crn) report("corner", got.crn, e.crn);
            if (got.kp !== e.kp) report("kept_point", got.kp, e.kp);
            if (got.lastv !== e.lastv) report("last_vertex", got.lastv, e.lastv);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic final_point = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] vertex_x, vertex_y, vertex_z;
    logic [1:0] corner;
    logic [3:0] kept_point;
    logic last_vertex;
    bit calm = 1'b0;

    vertex_scoreboard sb = new();

    tapered_trail_vertex_builder_top #(.MAX_POINTS(MAX_PTS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function bit idle_now();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    always @(posedge clk)
    begin
        vertex_t g;
        if (rst_n && out_valid && out_ready)
        begin
            g.vx = vertex_x; g.vy = vertex_y; g.vz = vertex_z;
            g.crn = corner; g.kp = kept_point; g.lastv = last_vertex;
            sb.check_vertex(g);
        end
        out_ready <= !idle_now();
    end

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic fin);
        if (idle_now())
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (idle_now());
        end
        in_valid <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        final_point <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_point(px, py, pz, fin);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_decay(logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_write_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.decay = val;
    endtask

    function logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
            default: return $signed($urandom_range(4000)) - 2000;
        endcase
    endfunction

    task automatic random_trail(int len, int mode);
        logic signed [31:0] x, y, z;
        x = rand_coord(mode);
        y = rand_coord(mode);
        z = rand_coord(mode);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                x = rand_coord(0); y = rand_coord(0); z = rand_coord(0);
            end
            else if ($urandom_range(7) == 0)
                ;
            else
            begin
                x += rand_coord(2) * 32;
                y += rand_coord(2) * (($urandom_range(3) == 0) ? 0 : 32);
                z += rand_coord(2) * 32;
            end
            send_point(x, y, z, i == len - 1);
        end
    endtask

    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PMIN = 32'sh80000000;
    localparam int DIRECTED = 24;
    int sent;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(0, 0, 0, 1'b1);
        send_point(PMAX, PMIN, PMAX, 1'b0);
        send_point(PMIN, PMAX, PMIN, 1'b1);
        send_point(65536, 0, 0, 1'b0);
        send_point(65536, 0, 0, 1'b0);
        send_point(65536, 5 * 65536, 0, 1'b1);
        send_point(-1, -1, -1, 1'b0);
        send_point(0, 0, 0, 1'b1);
        for (int i = 0; i < 16; i++)
            send_point(i * 65536, -i * 3000, i * i * 100, i == 15);
        drain();
        sent = DIRECTED;

        set_decay(16'd0);
        random_trail(18, 1);
        drain();
        set_decay(16'hFFFF);
        random_trail(16, 1);
        random_trail(5, 0);
        drain();
        set_decay(16'd30000);
        random_trail(10, 2);
        drain();
        sent += 49;

        calm = 1'b1;
        set_decay(16'd6554);
        random_trail(8, 1);
        drain();
        calm = 1'b0;
        sent += 8;

        while (sent < 280)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 8);
            if ($urandom_range(7) == 0)
            begin
                drain();
                set_decay($urandom());
            end
            random_trail(len, $urandom_range(2));
            sent += len;
        end
        drain();

        $display("Sent %0d points in %0d builds, checked %0d vertices.",
                 sent, sb.builds, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("Timeout reached");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
